// ===== src/sobel_pkg.sv =====
// ----------------------------------------------------------------------------
// sobel_pkg
// Types and constants shared by the Sobel edge threshold block, its checker and testbench.
// ----------------------------------------------------------------------------
package sobel_pkg;

  // Field widths
  localparam int PIX_W      = 8;
  localparam int OUT_ROW_W  = 12;
  localparam int OUT_COL_W  = 10;
  localparam int IMG_W_W    = 11;
  localparam int IMG_H_W    = 13;
  localparam int THRESH_W   = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH    = 2'd0,
    REG_IMAGE_HEIGHT   = 2'd1,
    REG_EDGE_THRESHOLD = 2'd2
  } cfg_reg_t;

  // Reset values of the registers
  localparam int IMG_W_RESET  = 640;
  localparam int IMG_H_RESET  = 480;
  localparam int THRESH_RESET = 127;
  localparam int MIN_SIZE     = 3;

  // Gray conversion: floor(sum / 3) = (sum * 683) >> 11 for sum <= 765
  localparam int SUM3_W      = 10;
  localparam int GRAY_PROD_W = 20;
  localparam int GRAY_RECIP  = 683;
  localparam int GRAY_SHIFT  = 11;

  // Gradient and magnitude
  localparam int GRAD_W     = 12;   // signed, |g| <= 1020
  localparam int ABS_W      = 10;
  localparam int RAD_W      = 22;   // gx^2 + gy^2, padded to an even width
  localparam int ROOT_W     = 11;
  localparam int ROOT_STEPS = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 1;
  localparam int TRIAL_W    = ROOT_W + 3;
  localparam int STEP_W     = $clog2(ROOT_STEPS);
  localparam logic [PIX_W-1:0] EDGE_MAX = 8'hFF;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic [OUT_ROW_W-1:0] out_row;
    logic [OUT_COL_W-1:0] out_col;
    logic [PIX_W-1:0]     edge_value;
    logic                 frame_last;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_GRAD,
    ST_SQUARE,
    ST_ROOT,
    ST_OUT
  } sobel_state_t;

endpackage

// ===== src/sobel_ram.sv =====
// ----------------------------------------------------------------------------
// sobel_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sobel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/sobel_edge_threshold.sv =====
// ----------------------------------------------------------------------------
// sobel_edge_threshold
// Gray conversion, two line stores in RAM, 3x3 Sobel window, bit-serial
// square root and threshold. One result per interior pixel.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+----------------------
//   pixel    | in        | pixel_valid / pixel_ready | pixel_t (b, g, r)
//   result   | out       | result_valid/result_ready | result_t
//   cfg      | in        | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// A border pixel passes through transfer and line store read-modify-write.
// An interior pixel passes through transfer, line store update, gradient,
// squares, 11 steps of the one-bit-per-cycle square root, output load.
// Reset is synchronous; line stores are not cleared, no clearing pass.
// A stalled result holds the block in its output state until taken.
// ----------------------------------------------------------------------------
module sobel_edge_threshold
  import sobel_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pixel_valid,
  output logic                  pixel_ready,
  input  pixel_t                pixel,
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WLW = $clog2(MAX_WIDTH + 1);
  localparam int HLW = $clog2(MAX_HEIGHT + 1);
  localparam int W_RESET = (MAX_WIDTH < IMG_W_RESET) ? MAX_WIDTH : IMG_W_RESET;
  localparam int H_RESET = (MAX_HEIGHT < IMG_H_RESET) ? MAX_HEIGHT : IMG_H_RESET;

  // Configuration (held clamped)
  logic [WLW-1:0]      width_lim;
  logic [HLW-1:0]      height_lim;
  logic [THRESH_W-1:0] threshold;
  logic [IMG_W_W-1:0]  raw_w;
  logic [IMG_H_W-1:0]  raw_h;
  logic [WLW-1:0]      w_clamp;
  logic [HLW-1:0]      h_clamp;

  // Control
  sobel_state_t state, state_next;
  logic [CW-1:0]     col_count;
  logic [RW-1:0]     row_count;
  logic [STEP_W-1:0] step;
  logic              accept;
  logic              ram_we;
  logic              out_free;
  logic              interior;
  logic              root_done;

  // Datapath
  logic [SUM3_W-1:0]      sum3;
  logic [GRAY_PROD_W-1:0] gray_prod;
  logic [PIX_W-1:0]       gray;
  logic [PIX_W-1:0]       upper_rdata;
  logic [PIX_W-1:0]       middle_rdata;
  logic [PIX_W-1:0]       win [9];
  logic [GRAD_W-1:0]      gx, gy;
  logic [ABS_W-1:0]       ax, ay;
  logic [RAD_W-1:0]       rad;
  logic [REM_W-1:0]       rem;
  logic [ROOT_W-1:0]      root;
  logic [TRIAL_W-1:0]     rem_shift, trial, diff;
  logic [OUT_ROW_W-1:0]   meta_row;
  logic [OUT_COL_W-1:0]   meta_col;
  logic                   meta_last;
  logic [WLW-1:0]         c_plus;
  logic [HLW-1:0]         r_plus;

  assign cfg_ready = 1'b1;
  assign accept    = pixel_valid && pixel_ready;
  assign out_free  = !result_valid || result_ready;

  // ---------------- configuration ----------------
  always_comb begin
    raw_w = cfg_data[IMG_W_W-1:0];
    raw_h = cfg_data[IMG_H_W-1:0];
    if (raw_w < IMG_W_W'(MIN_SIZE)) begin
      w_clamp = WLW'(MIN_SIZE);
    end else if (32'(raw_w) > MAX_WIDTH) begin
      w_clamp = WLW'(MAX_WIDTH);
    end else begin
      w_clamp = WLW'(raw_w);
    end
    if (raw_h < IMG_H_W'(MIN_SIZE)) begin
      h_clamp = HLW'(MIN_SIZE);
    end else if (32'(raw_h) > MAX_HEIGHT) begin
      h_clamp = HLW'(MAX_HEIGHT);
    end else begin
      h_clamp = HLW'(raw_h);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_lim  <= WLW'(W_RESET);
      height_lim <= HLW'(H_RESET);
      threshold  <= THRESH_W'(THRESH_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:    width_lim  <= w_clamp;
        REG_IMAGE_HEIGHT:   height_lim <= h_clamp;
        REG_EDGE_THRESHOLD: threshold  <= cfg_data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- line stores ----------------
  // Read at transfer, write back in ST_LOAD; the next transfer cannot come
  // before the write, so no forwarding is needed.
  sobel_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (ram_we),
    .waddr (col_count),
    .wdata (middle_rdata),
    .re    (accept),
    .raddr (col_count),
    .rdata (upper_rdata)
  );

  sobel_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (ram_we),
    .waddr (col_count),
    .wdata (gray),
    .re    (accept),
    .raddr (col_count),
    .rdata (middle_rdata)
  );

  // ---------------- gray ----------------
  assign sum3      = SUM3_W'(pixel.blue) + SUM3_W'(pixel.green) + SUM3_W'(pixel.red);
  assign gray_prod = GRAY_PROD_W'(sum3) * GRAY_PROD_W'(GRAY_RECIP);

  always_ff @(posedge clk) begin
    if (accept) begin
      gray <= PIX_W'(gray_prod >> GRAY_SHIFT);
    end
  end

  // ---------------- position ----------------
  assign c_plus = WLW'(col_count) + WLW'(1);
  assign r_plus = HLW'(row_count) + HLW'(1);
  assign interior = (HLW'(row_count) >= HLW'(2)) && (WLW'(col_count) >= WLW'(2)) &&
                    (WLW'(col_count) < width_lim) && (HLW'(row_count) < height_lim);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (ram_we) begin
      if (c_plus >= width_lim) begin
        col_count <= '0;
        row_count <= (r_plus >= height_lim) ? '0 : RW'(r_plus);
      end else begin
        col_count <= CW'(c_plus);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      meta_row  <= OUT_ROW_W'(HLW'(row_count) - HLW'(1));
      meta_col  <= OUT_COL_W'(WLW'(col_count) - WLW'(1));
      meta_last <= (HLW'(row_count) == height_lim - HLW'(1)) &&
                   (WLW'(col_count) == width_lim - WLW'(1));
    end
  end

  // ---------------- window ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (ram_we) begin
      for (int k = 0; k < 3; k++) begin
        win[k*3]   <= win[k*3+1];
        win[k*3+1] <= win[k*3+2];
      end
      win[2] <= upper_rdata;
      win[5] <= middle_rdata;
      win[8] <= gray;
    end
  end

  // ---------------- gradient and squares ----------------
  assign gx = GRAD_W'(win[2]) + GRAD_W'(win[8]) + (GRAD_W'(win[5]) << 1)
            - GRAD_W'(win[0]) - GRAD_W'(win[6]) - (GRAD_W'(win[3]) << 1);
  assign gy = GRAD_W'(win[0]) + GRAD_W'(win[2]) + (GRAD_W'(win[1]) << 1)
            - GRAD_W'(win[6]) - GRAD_W'(win[8]) - (GRAD_W'(win[7]) << 1);

  always_ff @(posedge clk) begin
    if (state == ST_GRAD) begin
      ax <= gx[GRAD_W-1] ? ABS_W'(-gx) : ABS_W'(gx);
      ay <= gy[GRAD_W-1] ? ABS_W'(-gy) : ABS_W'(gy);
    end
  end

  // ---------------- square root, one bit per cycle ----------------
  assign rem_shift = {rem, rad[RAD_W-1 -: 2]};
  assign trial     = TRIAL_W'({root, 2'b01});
  assign diff      = rem_shift - trial;
  assign root_done = (step == STEP_W'(ROOT_STEPS - 1));

  always_ff @(posedge clk) begin
    if (state == ST_SQUARE) begin
      rad  <= RAD_W'((2 * ABS_W)'(ax) * (2 * ABS_W)'(ax)) +
              RAD_W'((2 * ABS_W)'(ay) * (2 * ABS_W)'(ay));
      rem  <= '0;
      root <= '0;
      step <= '0;
    end else if (state == ST_ROOT) begin
      rad  <= rad << 2;
      step <= step + STEP_W'(1);
      if (rem_shift >= trial) begin
        rem  <= REM_W'(diff);
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= REM_W'(rem_shift);
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      result.out_row    <= meta_row;
      result.out_col    <= meta_col;
      result.frame_last <= meta_last;
      result.edge_value <= (root > ROOT_W'(threshold)) ? EDGE_MAX : root[PIX_W-1:0];
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (pixel_valid) state_next = ST_LOAD;
      ST_LOAD:   state_next = interior ? ST_GRAD : ST_IDLE;
      ST_GRAD:   state_next = ST_SQUARE;
      ST_SQUARE: state_next = ST_ROOT;
      ST_ROOT:   if (root_done) state_next = ST_OUT;
      ST_OUT:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pixel_ready = 1'b0;
    ram_we      = 1'b0;
    unique case (state)
      ST_IDLE: pixel_ready = 1'b1;
      ST_LOAD: ram_we      = 1'b1;
      default: ;
    endcase
  end

  // ---------------- assertions ----------------
  a_we_after_transfer: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> $past(accept))
    else $error("line store write without a preceding pixel transfer");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_OUT)
    else $error("result raised outside the output state");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROOT |-> step < STEP_W'(ROOT_STEPS))
    else $error("square root step out of range");

  a_root_entry: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROOT && $past(state) != ST_ROOT) |-> step == '0)
    else $error("square root started without init");

endmodule

// ===== dv/sobel_edge_checker.sv =====
// ----------------------------------------------------------------------------
// sobel_edge_checker
// Watches the pixel, result and register channels of the Sobel edge block.
// Keeps its own copy of the line buffers, window and raster position,
// predicts each edge result at the pixel transfer and compares every result
// transfer field by field, in order.
// ----------------------------------------------------------------------------
module sobel_edge_checker
  import sobel_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pixel_valid,
  input  logic                  pixel_ready,
  input  pixel_t                pixel,
  input  logic                  result_valid,
  input  logic                  result_ready,
  input  result_t               result,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding,
  output int                    edges_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [IMG_W_W-1:0]  width_reg;
  logic [IMG_H_W-1:0]  height_reg;
  logic [THRESH_W-1:0] thresh_reg;
  logic [PIX_W-1:0]    upper_line  [MAX_WIDTH];
  logic [PIX_W-1:0]    middle_line [MAX_WIDTH];
  logic [PIX_W-1:0]    window      [9];   // [row*3+col], row 0 oldest, col 2 newest
  int                  col_pos;
  int                  row_pos;
  result_t             edge_q [$];
  result_t             want;

  function automatic int clamp_dim(int v, int hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  // Find the root one bit at a time from the top, then saturate above threshold.
  function automatic logic [PIX_W-1:0] edge_strength(int gx, int gy, int thr);
    int energy;
    int root;
    int trial;
    energy = gx * gx + gy * gy;
    root = 0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      trial = root | (1 << b);
      if (trial * trial <= energy) root = trial;
    end
    if (root > thr) return EDGE_MAX;
    return PIX_W'(root);
  endfunction

  task automatic take_pixel(input pixel_t px);
    int               w;
    int               h;
    int               c;
    int               r;
    int               sum;
    int               gx;
    int               gy;
    logic [PIX_W-1:0] gray;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] mid;
    result_t          res;
    w = clamp_dim(int'(width_reg), MAX_WIDTH);
    h = clamp_dim(int'(height_reg), MAX_HEIGHT);
    c = col_pos;
    r = row_pos;
    sum = int'(px.blue) + int'(px.green) + int'(px.red);
    gray = PIX_W'(sum / 3);
    // rotate the column through both line buffers
    up = upper_line[c];
    mid = middle_line[c];
    upper_line[c] = mid;
    middle_line[c] = gray;
    for (int k = 0; k < 3; k++) begin
      window[k*3]   = window[k*3+1];
      window[k*3+1] = window[k*3+2];
    end
    window[2] = up;
    window[5] = mid;
    window[8] = gray;
    if (r >= 2 && c >= 2 && c < w && r < h) begin
      gx = int'(window[2]) + 2 * int'(window[5]) + int'(window[8])
         - int'(window[0]) - 2 * int'(window[3]) - int'(window[6]);
      gy = int'(window[0]) + 2 * int'(window[1]) + int'(window[2])
         - int'(window[6]) - 2 * int'(window[7]) - int'(window[8]);
      res.out_row    = OUT_ROW_W'(r - 1);
      res.out_col    = OUT_COL_W'(c - 1);
      res.edge_value = edge_strength(gx, gy, int'(thresh_reg));
      res.frame_last = (r == h - 1 && c == w - 1);
      edge_q.push_back(res);
    end
    // a position past a shrunken size simply wraps
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = IMG_W_RESET;
      height_reg = IMG_H_RESET;
      thresh_reg = THRESH_RESET;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      for (int i = 0; i < 9; i++) window[i] = '0;
      col_pos = 0;
      row_pos = 0;
      edge_q.delete();
      mismatches = 0;
      edges_checked = 0;
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_WIDTH: begin
            width_reg = cfg_data[IMG_W_W-1:0];
          end
          REG_IMAGE_HEIGHT: begin
            height_reg = cfg_data[IMG_H_W-1:0];
          end
          REG_EDGE_THRESHOLD: begin
            thresh_reg = cfg_data[THRESH_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (pixel_valid && pixel_ready) take_pixel(pixel);
      if (result_valid && result_ready) begin
        if (edge_q.size() == 0) begin
          $error("result with none expected: out_row %0d out_col %0d edge_value %0d",
                 result.out_row, result.out_col, result.edge_value);
          mismatches++;
        end else begin
          want = edge_q.pop_front();
          edges_checked++;
          if (result.out_row !== want.out_row) begin
            $error("out_row: expected %0d, got %0d", want.out_row, result.out_row);
            mismatches++;
          end
          if (result.out_col !== want.out_col) begin
            $error("out_col: expected %0d, got %0d", want.out_col, result.out_col);
            mismatches++;
          end
          if (result.edge_value !== want.edge_value) begin
            $error("edge_value: expected %0d, got %0d", want.edge_value, result.edge_value);
            mismatches++;
          end
          if (result.frame_last !== want.frame_last) begin
            $error("frame_last: expected %0d, got %0d", want.frame_last, result.frame_last);
            mismatches++;
          end
        end
      end
      outstanding <= edge_q.size();
    end
  end

endmodule

// ===== dv/sobel_edge_threshold_tb.sv =====
// ----------------------------------------------------------------------------
// sobel_edge_threshold_tb
// Streams whole frames of colour pixels through the Sobel edge block with
// random gaps and result back-pressure. Covers the reset threshold and height,
// clamped sizes, dropped upper register bits, resizes inside a frame and random
// small frames; the checker predicts and compares every edge result.
// ----------------------------------------------------------------------------
module sobel_edge_threshold_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sobel_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int MAX_W         = 1024;
  localparam int MAX_H         = 4096;
  localparam int DRAIN_CYCLES  = 32;
  localparam int RANDOM_PIXELS = 950;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;   // unmapped, must be ignored

  typedef enum int {
    PAT_NOISE,
    PAT_RAMP,
    PAT_STEP,
    PAT_EXTREME,
    PAT_FLAT
  } pattern_t;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  pixel_valid  = 1'b0;
  pixel_t                pixel        = '0;
  logic                  result_ready = 1'b0;
  logic                  cfg_valid    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  pixel_ready;
  logic                  result_valid;
  result_t               result;
  logic                  cfg_ready;

  int mismatches;
  int outstanding;
  int edges_checked;
  int pixels_sent = 0;
  int frames_sent = 0;
  int level       = 0;
  int step_col    = 1;
  bit pix_calm    = 1'b0;
  bit res_calm    = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  sobel_edge_threshold #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  sobel_edge_checker #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) u_check (
    .clk           (clk),
    .rst           (rst),
    .pixel_valid   (pixel_valid),
    .pixel_ready   (pixel_ready),
    .pixel         (pixel),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result        (result),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .edges_checked (edges_checked)
  );

  function automatic pixel_t make_pixel(pattern_t pat, int col, int row);
    pixel_t px;
    int     v;
    case (pat)
      PAT_RAMP: begin
        v = level + 3 * col + 2 * row + $urandom_range(0, 4);
        px.blue  = PIX_W'(v);
        px.green = PIX_W'(v + $urandom_range(0, 2));
        px.red   = PIX_W'(v + $urandom_range(0, 2));
      end
      PAT_STEP: begin
        v = (col >= step_col) ? level : 255 - level;
        px.blue  = PIX_W'(v);
        px.green = PIX_W'(v);
        px.red   = PIX_W'(v);
      end
      PAT_EXTREME: begin
        px.blue  = $urandom_range(0, 1) ? '1 : '0;
        px.green = $urandom_range(0, 1) ? '1 : '0;
        px.red   = $urandom_range(0, 1) ? '1 : '0;
      end
      PAT_FLAT: begin
        px.blue  = PIX_W'(level);
        px.green = PIX_W'(level);
        px.red   = PIX_W'(level);
      end
      default: begin
        px.blue  = PIX_W'($urandom);
        px.green = PIX_W'($urandom);
        px.red   = PIX_W'($urandom);
      end
    endcase
    return px;
  endfunction

  task automatic send_pixel(input pixel_t px);
    int gap;
    if ($urandom_range(0, 63) == 0) pix_calm = !pix_calm;
    gap = pix_calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel       <= px;
    pixel_valid <= 1'b1;
    do @(posedge clk); while (!(pixel_valid && pixel_ready));
    pixels_sent++;
  endtask

  // Walk n pixels in raster order; position only shapes the pattern.
  task automatic send_run(input int w, input int col, input int row, input int n,
                          input pattern_t pat);
    for (int i = 0; i < n; i++) begin
      send_pixel(make_pixel(pat, col, row));
      col++;
      if (col == w) begin
        col = 0;
        row++;
      end
    end
  endtask

  // Drop valid, let the count take in the last transfer, drain all pending
  // results, then cover border pixels still in flight.
  task automatic wait_idle();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] w_raw,
                           input logic [CFG_DATA_W-1:0] h_raw,
                           input logic [CFG_DATA_W-1:0] t_raw);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, w_raw);
    write_reg(REG_IMAGE_HEIGHT, h_raw);
    write_reg(REG_EDGE_THRESHOLD, t_raw);
  endtask

  // Result side back-pressure.
  initial begin
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) res_calm = !res_calm;
      gap = res_calm ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!(result_valid && result_ready));
    end
  end

  initial begin
    #50ms;
    $error("timeout with %0d results still pending", outstanding);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int                    w;
    int                    h;
    int                    thr;
    int                    random_start;
    pattern_t              pat;
    logic [CFG_DATA_W-1:0] w_raw;
    logic [CFG_DATA_W-1:0] h_raw;
    logic [CFG_DATA_W-1:0] t_raw;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset height and threshold: three rows at width 8, then cut the frame to four rows
    write_reg(REG_IMAGE_WIDTH, 13'd8);
    send_run(8, 0, 0, 24, PAT_NOISE);
    wait_idle();
    write_reg(REG_IMAGE_HEIGHT, 13'd4);
    send_run(8, 0, 3, 8, PAT_NOISE);
    frames_sent++;

    // sizes below the minimum clamp to 3x3; threshold 0 saturates any edge
    configure(13'd0, 13'd1, 13'd0);
    send_run(3, 0, 0, 9, PAT_EXTREME);
    level = 255;
    send_run(3, 0, 0, 9, PAT_FLAT);
    frames_sent += 2;

    // top threshold: moderate edges pass through unsaturated
    configure(13'd3, 13'd3, 13'd255);
    level = 140;
    step_col = 1;
    send_run(3, 0, 0, 9, PAT_STEP);
    level = 0;
    send_run(3, 0, 0, 9, PAT_FLAT);
    wait_idle();
    write_reg(REG_SPARE, 13'h1FFF);
    send_run(3, 0, 0, 9, PAT_EXTREME);
    frames_sent += 3;

    // bits above each register's width are dropped: width 5, threshold 64
    level = 30;
    configure(13'h1805, 13'd4, 13'h1F40);
    send_run(5, 0, 0, 20, PAT_RAMP);
    frames_sent++;

    // narrow the frame partway through row 2; the rest wraps to width 3
    configure(13'd6, 13'd5, 13'd60);
    send_run(6, 0, 0, 16, PAT_NOISE);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, 13'd3);
    send_run(3, 0, 3, 7, PAT_NOISE);
    frames_sent++;

    // tallest frame reached through clamping, then cut to five rows
    level = $urandom_range(0, 255);
    configure(13'd3, 13'd8191, 13'd200);
    send_run(3, 0, 0, 12, PAT_RAMP);
    wait_idle();
    write_reg(REG_IMAGE_HEIGHT, 13'd5);
    send_run(3, 0, 4, 3, PAT_RAMP);
    frames_sent++;

    // random small frames
    random_start = pixels_sent;
    while (pixels_sent - random_start < RANDOM_PIXELS) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
      h = $urandom_range(3, 8);
      case ($urandom_range(0, 5))
        0: thr = 0;
        1: thr = 255;
        default: thr = $urandom_range(0, 255);
      endcase
      if (w == MIN_SIZE && $urandom_range(0, 1))
        w_raw = CFG_DATA_W'($urandom_range(0, 2));
      else
        w_raw = CFG_DATA_W'(w + ($urandom_range(0, 3) << IMG_W_W));
      if (h == MIN_SIZE && $urandom_range(0, 1))
        h_raw = CFG_DATA_W'($urandom_range(0, 2));
      else
        h_raw = CFG_DATA_W'(h);
      t_raw = CFG_DATA_W'(thr + ($urandom_range(0, 31) << THRESH_W));
      pat = pattern_t'($urandom_range(0, 4));
      level = $urandom_range(0, 255);
      step_col = $urandom_range(1, w - 1);
      configure(w_raw, h_raw, t_raw);
      send_run(w, 0, 0, w * h, pat);
      frames_sent++;
    end

    wait_idle();
    $display("Checked %0d edge results from %0d pixels in %0d frames.",
             edges_checked, pixels_sent, frames_sent);
    $display("Sizes ran from 3x3 to 40x8 plus clamped and in-frame resizes, thresholds 0 to 255.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sobel_pkg.sv
src/sobel_ram.sv
src/sobel_edge_threshold.sv
dv/sobel_edge_checker.sv
dv/sobel_edge_threshold_tb.sv
